@@ design/set_assoc_cache_lru_lookup_top_macros.svh @@
// Assertion macros for the set-associative cache lookup block.
// No dependencies; taken in by the modules that carry assertions.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold at every clock edge out of reset.
`define SCL_ASSERT(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);
// Condition that, when true, implies another one at the next edge.
`define SCL_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (pre) |=> (post)) else $error(msg);
`else
`define SCL_ASSERT(lbl, clk_s, rstn_s, cond, msg)
`define SCL_ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post, msg)
`endif
`endif

@@ design/scl_pkg.sv @@
// Shared constants and helpers for the set-associative cache lookup block.
// No dependencies; used by all modules of the block.
package scl_pkg;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int OUT_DATA_W = 72;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

  // Index width for a count of n, never below one bit.
  function automatic int idx_w(input int n);
    int w;
    w = $clog2(n);
    return (w < 1) ? 1 : w;
  endfunction

endpackage

@@ design/scl_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
// Depends on scl_pkg for the index width helper.
module scl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [scl_pkg::idx_w(DEPTH)-1:0]      waddr,
  input  logic [DATA_W-1:0]                     wdata,
  input  logic                                  re,
  input  logic [scl_pkg::idx_w(DEPTH)-1:0]      raddr,
  output logic [DATA_W-1:0]                     rdata
);
  import scl_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/scl_lookup.sv @@
// Tag compare, victim choice and LRU age update for one set row.
// Depends on scl_pkg; purely combinational, fed from the row memories.
module scl_lookup #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 17
) (
  input  logic [WAYS*(scl_pkg::idx_w(WAYS)+1)-1:0] lru_row_i,
  input  logic [WAYS*TAG_W-1:0]                    tag_row_i,
  input  logic [TAG_W-1:0]                         req_tag,
  output logic                                     hit,
  output logic [scl_pkg::idx_w(WAYS)-1:0]          way,
  output logic [WAYS*(scl_pkg::idx_w(WAYS)+1)-1:0] lru_row_o,
  output logic [WAYS*TAG_W-1:0]                    tag_row_o
);
  import scl_pkg::*;

  localparam int AGE_W = idx_w(WAYS);
  localparam int WAY_W = idx_w(WAYS);
  localparam int ENT_W = AGE_W + 1;

  logic [WAYS-1:0]  vld;
  logic [WAYS-1:0]  match;
  logic [AGE_W-1:0] age [WAYS];
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic [AGE_W-1:0] old_age;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      vld[i]   = lru_row_i[i*ENT_W];
      age[i]   = lru_row_i[i*ENT_W+1 +: AGE_W];
      match[i] = vld[i] && (tag_row_i[i*TAG_W +: TAG_W] == req_tag);
    end
  end

  // Lowest matching way wins.
  always_comb begin
    hit_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
    end
  end

  // First invalid way, otherwise the oldest valid way with ties to the lowest.
  always_comb begin
    logic             found_inv;
    logic             have;
    logic [AGE_W-1:0] best;
    found_inv = 1'b0;
    have      = 1'b0;
    best      = '0;
    victim    = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found_inv) begin
        if (!vld[i]) begin
          victim    = WAY_W'(i);
          found_inv = 1'b1;
        end else if (!have || (age[i] > best)) begin
          best   = age[i];
          victim = WAY_W'(i);
          have   = 1'b1;
        end
      end
    end
  end

  assign hit     = |match;
  assign way     = hit ? hit_way : victim;
  assign old_age = age[way];

  always_comb begin
    lru_row_o = lru_row_i;
    tag_row_o = tag_row_i;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == way) begin
        lru_row_o[i*ENT_W]             = 1'b1;
        lru_row_o[i*ENT_W+1 +: AGE_W]  = '0;
        if (!hit) begin
          tag_row_o[i*TAG_W +: TAG_W] = req_tag;
        end
      end else if (vld[i] && (!hit || (age[i] < old_age))) begin
        lru_row_o[i*ENT_W+1 +: AGE_W] = AGE_W'(age[i] + 1'b1);
      end
    end
  end

endmodule

@@ design/set_assoc_cache_lru_lookup_top.sv @@
// Top level of the set-associative cache lookup block with true LRU replacement.
// Depends on scl_pkg, scl_ram, scl_lookup and the assertion macro header.
//
//  Channel  Direction  tdata                 tuser
//  in_      slave      address               req_type
//  out_     master     way/hit/access count  hit
//
// Each item first gets the synchronous read of the tag and LRU rows of its set,
// then compare, age update and write-back (a clear zeroes the counters); the
// next item is taken once that is done. After reset a clearing pass writes the
// LRU row of each of the CACHE_BYTES/(WAYS*BLOCK_BYTES) sets (512 by default),
// one set a cycle, with in_tready low. A stalled output holds the finished item
// in the row stage. CACHE_BYTES, WAYS and BLOCK_BYTES are powers of two.
module set_assoc_cache_lru_lookup_top #(
  parameter int CACHE_BYTES = 262144,
  parameter int WAYS        = 8,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scl_pkg::ADDR_W-1:0]     in_tdata,   // [31:0] address
  input  logic                           in_tuser,   // [0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [scl_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] way_used, [34:3] hit_count,
                                                     // [66:35] access_count, rest zero
  output logic                           out_tuser   // [0] hit
);
  import scl_pkg::*;
  `include "set_assoc_cache_lru_lookup_top_macros.svh"

  localparam int SETS_RAW = CACHE_BYTES / (WAYS * BLOCK_BYTES);
  localparam int NUM_SETS = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int OFF_W    = $clog2(BLOCK_BYTES);
  localparam int SET_B    = $clog2(NUM_SETS);
  localparam int SET_W    = idx_w(NUM_SETS);
  localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int TAG_RAW  = EFF_BITS - OFF_W - SET_B;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int AGE_W    = idx_w(WAYS);
  localparam int WAY_W    = idx_w(WAYS);
  localparam int LRU_W    = WAYS * (AGE_W + 1);
  localparam int TROW_W   = WAYS * TAG_W;
  localparam int WIDE_W   = ADDR_W + OFF_W + SET_B + TAG_W;

  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                            ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [WIDE_W-1:0] SET_MASK  = WIDE_W'(NUM_SETS - 1);
  localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(NUM_SETS - 1);

  logic              in_acc;
  logic [WIDE_W-1:0] addr_ext;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;

  logic              clr_r;
  logic [SET_W-1:0]  clr_idx_r;

  logic              s1_v_r;
  logic              s1_req_r;
  logic [SET_W-1:0]  s1_set_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic              s1_fire;

  logic [LRU_W-1:0]  lru_rd;
  logic [TROW_W-1:0] tag_rd;
  logic [LRU_W-1:0]  lru_new;
  logic [TROW_W-1:0] tag_new;
  logic              lk_hit;
  logic [WAY_W-1:0]  lk_way;

  logic              lru_we;
  logic [SET_W-1:0]  lru_waddr;
  logic [LRU_W-1:0]  lru_wdata;
  logic              tag_we;
  logic              is_clear;

  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;

  logic                  out_v_r;
  logic                  out_hit_r;
  logic [WAY_OUT_W-1:0]  out_way_r;
  logic [CNT_W-1:0]      out_hits_r;
  logic [CNT_W-1:0]      out_acc_r;

  assign addr_ext = WIDE_W'(in_tdata & ADDR_MASK);
  assign in_set   = SET_W'((addr_ext >> OFF_W) & SET_MASK);
  assign in_tag   = TAG_W'(addr_ext >> (OFF_W + SET_B));

  assign in_tready = !clr_r && !s1_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_fire   = s1_v_r && (!out_v_r || out_tready);
  assign is_clear  = (s1_req_r == REQ_CLEAR);

  // The clearing pass owns the LRU write port; no item is in flight then.
  always_comb begin
    if (clr_r) begin
      lru_we    = 1'b1;
      lru_waddr = clr_idx_r;
      lru_wdata = '0;
    end else begin
      lru_we    = s1_fire && !is_clear;
      lru_waddr = s1_set_r;
      lru_wdata = lru_new;
    end
  end
  assign tag_we = s1_fire && !is_clear && !lk_hit;

  scl_ram #(.DATA_W(LRU_W), .DEPTH(NUM_SETS)) u_lru_ram (
    .clk   (clk),
    .we    (lru_we),
    .waddr (lru_waddr),
    .wdata (lru_wdata),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (lru_rd)
  );

  scl_ram #(.DATA_W(TROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (s1_set_r),
    .wdata (tag_new),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (tag_rd)
  );

  scl_lookup #(.WAYS(WAYS), .TAG_W(TAG_W)) u_lookup (
    .lru_row_i (lru_rd),
    .tag_row_i (tag_rd),
    .req_tag   (s1_tag_r),
    .hit       (lk_hit),
    .way       (lk_way),
    .lru_row_o (lru_new),
    .tag_row_o (tag_new)
  );

  always_comb begin
    hits_nxt = hits_r;
    acc_nxt  = acc_r;
    if (is_clear) begin
      hits_nxt = '0;
      acc_nxt  = '0;
    end else begin
      if (lk_hit && (hits_r != CNT_MAX)) begin
        hits_nxt = hits_r + 1'b1;
      end
      if (acc_r != CNT_MAX) begin
        acc_nxt = acc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      hits_r    <= '0;
      acc_r     <= '0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SET) begin
          clr_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
        hits_r  <= hits_nxt;
        acc_r   <= acc_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_tuser;
      s1_set_r <= in_set;
      s1_tag_r <= in_tag;
    end
    if (s1_fire) begin
      out_hit_r  <= is_clear ? 1'b0 : lk_hit;
      out_way_r  <= is_clear ? '0 : WAY_OUT_W'(lk_way);
      out_hits_r <= hits_nxt;
      out_acc_r  <= acc_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_DATA_W'({out_acc_r, out_hits_r, out_way_r});

  `SCL_ASSERT(a_no_accept_in_clear, clk, rst_n, !(clr_r && in_tready), "item accepted during clearing pass")
  `SCL_ASSERT(a_single_in_flight, clk, rst_n, !(s1_v_r && in_tready), "second item taken while one is in flight")
  `SCL_ASSERT_NEXT(a_fire_gives_out, clk, rst_n, s1_fire, out_tvalid, "finished item not presented")
  `SCL_ASSERT(a_hits_le_access, clk, rst_n, !out_tvalid || (out_tdata[34:3] <= out_tdata[66:35]), "hit count exceeds access count")

endmodule
